/* rtl/donchian_channel_assert.svh */
// Assertion macros for the Donchian channel block.
// Needs clk and arst_n in the scope where a macro is used.
`ifndef DONCHIAN_CHANNEL_ASSERT_SVH
`define DONCHIAN_CHANNEL_ASSERT_SVH

// Property that holds at every clock edge outside reset.
`define DCH_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Property whose consequence is checked in the cycle after the trigger.
`define DCH_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

/* rtl/dch_pkg.sv */
// Shared types, step addresses and control store for the Donchian channel.
// Depends on nothing; used by the sequencer, the datapath and the top level.
`default_nettype none

package dch_pkg;

	localparam int PERIOD_W = 7;
	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 7'd20;

	localparam int STEP_W = 3;
	localparam logic [STEP_W-1:0] STEP_IDLE  = 3'd0;
	localparam logic [STEP_W-1:0] STEP_STORE = 3'd1;
	localparam logic [STEP_W-1:0] STEP_TEST  = 3'd2;
	localparam logic [STEP_W-1:0] STEP_SCAN  = 3'd3;
	localparam logic [STEP_W-1:0] STEP_DONE  = 3'd4;
	localparam logic [STEP_W-1:0] STEP_EMPTY = 3'd5;

	typedef enum logic [2:0] {
		COND_ALWAYS,
		COND_ACCEPT,
		COND_SHORT,
		COND_SCAN,
		COND_OUT_FREE
	} cond_t;

	// Datapath operations of one step
	typedef struct packed {
		logic take;       // ready for a request, latch the bar
		logic store;      // write the bar; on append, advance pointer and fill count
		logic init;       // set up the scan
		logic scan;       // issue a read and fold the previous one
		logic load_band;  // load result register with the bands
		logic load_zero;  // load result register with an empty result
	} ctrl_t;

	typedef struct packed {
		logic shortfall;  // fewer bars held than the window
		logic scan_busy;  // reads outstanding or still to issue
		logic out_free;   // result register can take a new result
	} status_t;

	typedef struct packed {
		cond_t               cond;
		logic [STEP_W-1:0]   jt;
		logic [STEP_W-1:0]   jf;
		ctrl_t               op;
	} uword_t;

	localparam ctrl_t OP_NONE = '0;

	function automatic uword_t ucode_rom(input logic [STEP_W-1:0] addr);
		uword_t w;
		w = '{cond: COND_ALWAYS, jt: STEP_IDLE, jf: STEP_IDLE, op: OP_NONE};
		case (addr)
			STEP_IDLE: begin
				w.cond = COND_ACCEPT; w.jt = STEP_STORE; w.jf = STEP_IDLE;
				w.op.take = 1'b1;
			end
			STEP_STORE: begin
				w.cond = COND_ALWAYS; w.jt = STEP_TEST; w.jf = STEP_TEST;
				w.op.store = 1'b1;
			end
			STEP_TEST: begin
				w.cond = COND_SHORT; w.jt = STEP_EMPTY; w.jf = STEP_SCAN;
				w.op.init = 1'b1;
			end
			STEP_SCAN: begin
				w.cond = COND_SCAN; w.jt = STEP_SCAN; w.jf = STEP_DONE;
				w.op.scan = 1'b1;
			end
			STEP_DONE: begin
				w.cond = COND_OUT_FREE; w.jt = STEP_IDLE; w.jf = STEP_DONE;
				w.op.load_band = 1'b1;
			end
			STEP_EMPTY: begin
				w.cond = COND_OUT_FREE; w.jt = STEP_IDLE; w.jf = STEP_EMPTY;
				w.op.load_zero = 1'b1;
			end
			default: begin
				w.cond = COND_ALWAYS; w.jt = STEP_IDLE; w.jf = STEP_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

/* rtl/dch_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module dch_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

/* rtl/dch_seq.sv */
// Microcode sequencer: step counter, control store lookup and branch logic.
// Depends on dch_pkg.
`default_nettype none

module dch_seq
	import dch_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	input  wire status_t status,
	output ctrl_t        ctrl
);

	logic [STEP_W-1:0] upc_q;
	uword_t            word;
	logic              cond_met;

	assign word = ucode_rom(upc_q);
	assign ctrl = word.op;

	always_comb begin
		case (word.cond)
			COND_ALWAYS:   cond_met = 1'b1;
			COND_ACCEPT:   cond_met = in_valid;
			COND_SHORT:    cond_met = status.shortfall;
			COND_SCAN:     cond_met = status.scan_busy;
			COND_OUT_FREE: cond_met = status.out_free;
			default:       cond_met = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= STEP_IDLE;
		end else begin
			upc_q <= cond_met ? word.jt : word.jf;
		end
	end

endmodule

`default_nettype wire

/* rtl/dch_dpath.sv */
// Datapath: bar latch, ring pointers, scan accumulators and result register.
// Depends on dch_pkg and dch_ram; driven by the control word from dch_seq.
`default_nettype none

module dch_dpath
	import dch_pkg::*;
#(
	parameter int MAX_PERIOD = 64,
	parameter int PRICE_BITS = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire ctrl_t                 ctrl,
	output status_t                    status,
	input  wire logic                  in_valid,
	input  wire logic [PRICE_BITS-1:0] bar_high,
	input  wire logic [PRICE_BITS-1:0] bar_low,
	input  wire logic                  replace_last,
	input  wire logic                  cfg_we,
	input  wire logic [PERIOD_W-1:0]   cfg_wdata,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic      [PRICE_BITS-1:0] upper_band,
	output logic      [PRICE_BITS-1:0] lower_band,
	output logic                       band_valid
);

	localparam int PW = $clog2(MAX_PERIOD);
	localparam int CW = $clog2(MAX_PERIOD + 1);
	localparam logic [PW-1:0] LAST_SLOT = PW'(MAX_PERIOD - 1);
	localparam logic [CW-1:0] FULL = CW'(MAX_PERIOD);

	logic [PERIOD_W-1:0]   period_q;
	logic [PRICE_BITS-1:0] high_q, low_q;
	logic                  replace_q;
	logic [PW-1:0]         wp_q, rd_ptr_q;
	logic [CW-1:0]         fill_q, remain_q, p_eff;
	logic                  pend_q;
	logic [PRICE_BITS-1:0] top_q, bottom_q;

	logic [PW-1:0]           wr_slot, wp_prev, wp_next, rd_prev;
	logic                    append, issue;
	logic [2*PRICE_BITS-1:0] rd_data;
	logic [PRICE_BITS-1:0]   rd_high, rd_low;

	// Window length: zero means one bar, clamp at the store depth
	always_comb begin
		if (period_q == '0) begin
			p_eff = CW'(1);
		end else if (int'(period_q) > MAX_PERIOD) begin
			p_eff = FULL;
		end else begin
			p_eff = CW'(period_q);
		end
	end

	assign wp_prev = (wp_q == '0) ? LAST_SLOT : wp_q - PW'(1);
	assign wp_next = (wp_q == LAST_SLOT) ? '0 : wp_q + PW'(1);
	assign rd_prev = (rd_ptr_q == '0) ? LAST_SLOT : rd_ptr_q - PW'(1);
	assign append  = !(replace_q && fill_q != '0);
	assign wr_slot = append ? wp_q : wp_prev;
	assign issue   = ctrl.scan && remain_q != '0;

	assign rd_high = rd_data[2*PRICE_BITS-1:PRICE_BITS];
	assign rd_low  = rd_data[PRICE_BITS-1:0];

	assign status.shortfall = fill_q < p_eff;
	assign status.scan_busy = remain_q != '0 || pend_q;
	assign status.out_free  = !out_valid || out_ready;

	dch_ram #(
		.WIDTH(2 * PRICE_BITS),
		.DEPTH(MAX_PERIOD)
	) u_bars (
		.clk  (clk),
		.we   (ctrl.store),
		.waddr(wr_slot),
		.wdata({high_q, low_q}),
		.re   (issue),
		.raddr(rd_prev),
		.rdata(rd_data)
	);

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q  <= PERIOD_RESET;
			wp_q      <= '0;
			fill_q    <= '0;
			remain_q  <= '0;
			pend_q    <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_we) begin
				period_q <= cfg_wdata;
			end
			if (ctrl.store && append) begin
				wp_q <= wp_next;
				if (fill_q != FULL) begin
					fill_q <= fill_q + CW'(1);
				end
			end
			if (ctrl.init) begin
				// no reads when the window is not yet filled
				remain_q <= status.shortfall ? '0 : p_eff;
				pend_q   <= 1'b0;
			end else if (ctrl.scan) begin
				pend_q <= issue;
				if (issue) begin
					remain_q <= remain_q - CW'(1);
				end
			end
			if ((ctrl.load_band || ctrl.load_zero) && status.out_free) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (ctrl.take && in_valid) begin
			high_q    <= bar_high;
			low_q     <= bar_low;
			replace_q <= replace_last;
		end
		if (ctrl.init) begin
			rd_ptr_q <= wp_q;
			top_q    <= '0;
			bottom_q <= '1;
		end else if (ctrl.scan) begin
			if (issue) begin
				rd_ptr_q <= rd_prev;
			end
			// fold the word read in the previous cycle
			if (pend_q) begin
				if (rd_high > top_q) begin
					top_q <= rd_high;
				end
				if (rd_low < bottom_q) begin
					bottom_q <= rd_low;
				end
			end
		end
		if (status.out_free) begin
			if (ctrl.load_band) begin
				upper_band <= top_q;
				lower_band <= bottom_q;
				band_valid <= 1'b1;
			end else if (ctrl.load_zero) begin
				upper_band <= '0;
				lower_band <= '0;
				band_valid <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/donchian_channel.sv */
// Donchian channel: highest high and lowest low over the newest bars.
// Input channel in_valid/in_ready carries one bar (bar_high, bar_low,
// replace_last); output channel out_valid/out_ready carries one result
// (upper_band, lower_band, band_valid) for every request taken.
// cfg_we/cfg_wdata write the window length (period) at any clock edge;
// write it only while the block is idle.
// A request is taken only while the sequencer sits in its idle step. The
// bar is written to the ring store, then the store is read once per cycle
// from the newest bar backwards, one read port, one word per period bar.
// From accept, a bar passes the store, test and scan steps to the done step
// once the window is filled, and the store and test steps to the empty step
// while fewer than period bars are held. The next request is taken the cycle
// after the result is loaded; no bar is taken while the last is in work.
// The result register parts the two sides: a request may be taken while the
// previous result waits; if the receiver stalls, the sequencer holds in its
// final step until the result register is free.
// Reset clears the pointer, fill count and sequencer and sets period to 20;
// the ring store needs no clearing as only written entries are read.
`default_nettype none

`include "donchian_channel_assert.svh"

module donchian_channel
	import dch_pkg::*;
#(
	parameter int MAX_PERIOD = 64,
	parameter int PRICE_BITS = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [PRICE_BITS-1:0] bar_high,
	input  wire logic [PRICE_BITS-1:0] bar_low,
	input  wire logic                  replace_last,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic      [PRICE_BITS-1:0] upper_band,
	output logic      [PRICE_BITS-1:0] lower_band,
	output logic                       band_valid,
	input  wire logic                  cfg_we,
	input  wire logic [PERIOD_W-1:0]   cfg_wdata
);

	ctrl_t   ctrl;
	status_t status;

	assign in_ready = ctrl.take;

	dch_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.status  (status),
		.ctrl    (ctrl)
	);

	dch_dpath #(
		.MAX_PERIOD(MAX_PERIOD),
		.PRICE_BITS(PRICE_BITS)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (ctrl),
		.status      (status),
		.in_valid    (in_valid),
		.bar_high    (bar_high),
		.bar_low     (bar_low),
		.replace_last(replace_last),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.upper_band  (upper_band),
		.lower_band  (lower_band),
		.band_valid  (band_valid)
	);

	`DCH_ASSERT(a_empty_bands_zero, !(out_valid && !band_valid) || (upper_band == '0 && lower_band == '0), "bands not zero on an empty result")
	`DCH_ASSERT_NEXT(a_busy_after_take, in_valid && in_ready, !in_ready, "request taken while a bar is in work")
	`DCH_ASSERT(a_no_take_in_scan, !status.scan_busy || !in_ready, "ready raised during the store scan")

endmodule

`default_nettype wire
